FILE: hdl/ooc_pkg.sv
// Shared types, sizes and codes for the overvoltage offload controller.
// No dependencies; every other file imports this package.
package ooc_pkg;

    localparam int WINDOW      = 16;
    localparam int SAMPLE_BITS = 10;

    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int ENTRY_W = 12;
    localparam int SUM_W   = ENTRY_W + SLOT_W;

    localparam int DATA_W = 10;
    localparam int TPS_W  = 7;
    localparam int TICK_W = 8;
    localparam int OUT_SUM_W = 16;

    localparam logic [1:0] MODE_STABLE  = 2'd0;
    localparam logic [1:0] MODE_OFFLOAD = 2'd1;
    localparam logic [1:0] MODE_OFF     = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SAMPLE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SETPOINT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DUTY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_STEP   = 3'd4;

    typedef struct packed {
        logic              func;
        logic [DATA_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [1:0]                   mode;
        logic [DATA_W-1:0]            duty;
        logic                         server_connected;
        logic                         alarm;
        logic                         crowbar_on;
        logic                         led;
        logic signed [OUT_SUM_W-1:0]  window_sum;
    } result_t;

    typedef struct packed {
        logic [DATA_W-1:0] max_sample;
        logic [DATA_W-1:0] initial_setpoint;
        logic [DATA_W-1:0] start_duty;
        logic [DATA_W-1:0] max_duty;
        logic [TPS_W-1:0]  ticks_per_step;
    } cfg_t;

    // control -> window
    typedef struct packed {
        logic                      step;
        logic signed [ENTRY_W-1:0] fresh;
    } win_cmd_t;

    // window -> control
    typedef struct packed {
        logic signed [ENTRY_W-1:0] old;
        logic signed [SUM_W-1:0]   sum_next;
        logic signed [SUM_W-1:0]   sum;
    } win_stat_t;

    function automatic logic signed [OUT_SUM_W-1:0] sat_sum(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W+OUT_SUM_W:0] w;
        logic signed [SUM_W+OUT_SUM_W:0] hi;
        logic signed [SUM_W+OUT_SUM_W:0] lo;
        w  = (SUM_W+OUT_SUM_W+1)'(s);
        hi = (SUM_W+OUT_SUM_W+1)'((1 << (OUT_SUM_W-1)) - 1);
        lo = -hi - (SUM_W+OUT_SUM_W+1)'(1);
        if (w > hi)
            return hi[OUT_SUM_W-1:0];
        else if (w < lo)
            return lo[OUT_SUM_W-1:0];
        else
            return w[OUT_SUM_W-1:0];
    endfunction

endpackage

FILE: hdl/ooc_window.sv
// Ring window of WINDOW entries with its running sum and per-entry valid bits.
// Depends on ooc_pkg.
module ooc_window
    import ooc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  win_cmd_t  cmd,
    input  logic      clear,
    output win_stat_t stat
);

    logic signed [ENTRY_W-1:0] store_reg [WINDOW];
    logic [WINDOW-1:0]         valid_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic [SLOT_W-1:0]         slot_next;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;

    // slot advances before the write, so the entry read is the oldest one
    assign slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);

    always_comb
    begin
        stat.old      = valid_reg[slot_next] ? store_reg[slot_next] : '0;
        stat.sum_next = sum_reg - SUM_W'(stat.old) + SUM_W'(cmd.fresh);
        stat.sum      = sum_reg;
    end

    // alarm empties the window along with the sum
    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.step)
        begin
            sum_next = clear ? '0 : stat.sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            slot_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            if (cmd.step)
            begin
                slot_reg <= slot_next;
                if (clear)
                    valid_reg <= '0;
                else
                    valid_reg[slot_next] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && !clear)
            store_reg[slot_next] <= cmd.fresh;
    end

endmodule

FILE: hdl/ooc_ctrl.sv
// Mode, duty, setpoint ramp, tick counter and status flags; builds the result word.
// Depends on ooc_pkg; drives ooc_window through win_cmd_t.
module ooc_ctrl
    import ooc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      go,
    input  item_t     item,
    input  cfg_t      cfg,
    input  win_stat_t stat,
    output win_cmd_t  cmd,
    output logic      clear,
    output result_t   res
);

    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(WINDOW / 2);

    logic [1:0]        mode_reg, mode_next;
    logic [DATA_W-1:0] duty_reg, duty_next;
    logic [DATA_W-1:0] target_reg, target_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic              conn_reg, conn_next;
    logic              led_reg, led_next;
    logic              alarm_reg, alarm_next;
    logic              crowbar_reg, crowbar_next;

    logic [SAMPLE_BITS-1:0]   raw;
    logic signed [ENTRY_W:0]  delta;
    logic signed [SUM_W:0]    thresh;
    logic                     over;
    logic signed [SUM_W-1:0]  sum_after;

    assign raw    = item.sample[SAMPLE_BITS-1:0];
    assign thresh = $signed((SUM_W+1)'(cfg.max_sample) * (SUM_W+1)'(WINDOW));
    assign over   = (SUM_W+1)'(stat.sum_next) > thresh;
    assign delta  = (ENTRY_W+1)'(cmd.fresh) - (ENTRY_W+1)'(stat.old);
    assign clear  = (mode_reg == MODE_STABLE) && over;

    assign sum_after = !cmd.step ? stat.sum : (clear ? '0 : stat.sum_next);

    always_comb
    begin
        cmd.step  = go && !item.func && (mode_reg == MODE_STABLE || mode_reg == MODE_OFFLOAD);
        cmd.fresh = (mode_reg == MODE_STABLE)
                  ? ENTRY_W'($signed({1'b0, raw}))
                  : ENTRY_W'($signed({1'b0, raw})) - ENTRY_W'($signed({1'b0, target_reg}));
    end

    always_comb
    begin
        mode_next    = mode_reg;
        duty_next    = duty_reg;
        target_next  = target_reg;
        tick_next    = tick_reg;
        conn_next    = conn_reg;
        led_next     = led_reg;
        alarm_next   = alarm_reg;
        crowbar_next = crowbar_reg;

        if (cmd.step)
        begin
            case (mode_reg)
                MODE_STABLE:
                begin
                    if (over)
                    begin
                        conn_next   = 1'b0;
                        alarm_next  = 1'b1;
                        mode_next   = MODE_OFFLOAD;
                        duty_next   = cfg.start_duty;
                        target_next = cfg.initial_setpoint;
                        tick_next   = '0;
                    end
                end
                default:
                begin
                    if (stat.sum_next < -HALF && duty_reg != '0 && delta <= 0)
                        duty_next = duty_reg - DATA_W'(1);
                    else if (stat.sum_next > HALF && duty_reg < cfg.max_duty && delta >= 0)
                        duty_next = duty_reg + DATA_W'(1);
                end
            endcase
        end
        else if (go && item.func && mode_reg == MODE_OFFLOAD)
        begin
            tick_next = tick_reg + TICK_W'(1);
            if (tick_reg >= TICK_W'(cfg.ticks_per_step))
            begin
                if (target_reg == '0)
                begin
                    crowbar_next = 1'b1;
                    mode_next    = MODE_OFF;
                    led_next     = 1'b0;
                end
                else
                begin
                    led_next    = !led_reg;
                    target_next = target_reg - DATA_W'(1);
                    tick_next   = TICK_W'(1);
                end
            end
        end

        res.mode             = mode_next;
        res.duty             = duty_next;
        res.server_connected = conn_next;
        res.alarm            = alarm_next;
        res.crowbar_on       = crowbar_next;
        res.led              = led_next;
        res.window_sum       = sat_sum(sum_after);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_STABLE;
            duty_reg    <= '0;
            target_reg  <= '0;
            tick_reg    <= '0;
            conn_reg    <= 1'b1;
            led_reg     <= 1'b1;
            alarm_reg   <= 1'b0;
            crowbar_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            duty_reg    <= duty_next;
            target_reg  <= target_next;
            tick_reg    <= tick_next;
            conn_reg    <= conn_next;
            led_reg     <= led_next;
            alarm_reg   <= alarm_next;
            crowbar_reg <= crowbar_next;
        end
    end

endmodule

FILE: hdl/overvoltage_offload_controller.sv
// Overvoltage offload controller. One word in gives one result word out; a new word is
// taken every cycle unless result_stall holds a full result register. The word sits in
// the input register; the window/sum and control update lands in the result register.
// Depends on ooc_pkg, ooc_window and ooc_ctrl.
module overvoltage_offload_controller
    import ooc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    item_t     item_reg;
    logic      item_valid_reg;
    result_t   result_reg;
    logic      result_valid_reg;
    cfg_t      cfg_reg;
    logic      adv;
    win_cmd_t  cmd;
    logic      clear;
    win_stat_t stat;
    result_t   res;

    // input stage moves on when the result register is empty or being drained
    assign adv        = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && result_valid_reg && result_stall;
    assign cfg_ready  = 1'b1;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    ooc_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .clear (clear),
        .stat  (stat)
    );

    ooc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (adv),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .stat  (stat),
        .cmd   (cmd),
        .clear (clear),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
                item_valid_reg <= 1'b1;
            else if (adv)
                item_valid_reg <= 1'b0;

            if (adv)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            item_reg <= item;
        if (adv)
            result_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_sample       <= DATA_W'(1023);
            cfg_reg.initial_setpoint <= DATA_W'(512);
            cfg_reg.start_duty       <= '0;
            cfg_reg.max_duty         <= DATA_W'(1023);
            cfg_reg.ticks_per_step   <= TPS_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_SAMPLE:       cfg_reg.max_sample       <= cfg_data;
                CFG_INITIAL_SETPOINT: cfg_reg.initial_setpoint <= cfg_data;
                CFG_START_DUTY:       cfg_reg.start_duty       <= cfg_data;
                CFG_MAX_DUTY:         cfg_reg.max_duty         <= cfg_data;
                CFG_TICKS_PER_STEP:   cfg_reg.ticks_per_step   <= cfg_data[TPS_W-1:0];
                default:              ;
            endcase
        end
    end

endmodule
